// ===== rtl/jsu8_pkg.sv =====
// Package: payload structs, scan state struct, status codes and byte constants of the scanner.
`timescale 1ns / 1ps

package jsu8_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_END        = 2'd0,
        ST_QUOTE      = 2'd1,
        ST_INVALID    = 2'd2,
        ST_INCOMPLETE = 2'd3
    } t_status;

    // Input transaction payload
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [31:0] start_index;
    } t_in_item;

    // Output transaction payload
    typedef struct packed {
        t_status     status;
        logic [31:0] stop_index;
    } t_out_item;

    // Control part of the scan state
    typedef struct packed {
        logic [1:0] remaining_continuations;
        logic [7:0] held_lead;
        logic       sequence_bad;
        logic       discarding;
        logic       at_scan_start;
    } t_scan_state;

    // Byte constants
    localparam logic [7:0] ASCII_QUOTE     = 8'h22;
    localparam logic [7:0] ASCII_BACKSLASH = 8'h5C;
    localparam logic [7:0] ASCII_MAX       = 8'h7F;
    localparam logic [7:0] CONT_MASK       = 8'hC0;
    localparam logic [7:0] CONT_TAG        = 8'h80;
    localparam logic [7:0] LEAD2_PAYLOAD   = 8'h1E;
    localparam logic [7:0] LEAD4_MAX       = 8'hF4;
    localparam logic [7:0] CONT_BIT5       = 8'b0010_0000;
    localparam logic [7:0] CONT_BITS54     = 8'b0011_0000;
    localparam logic [3:0] LEAD3_SURR      = 4'b1101;
    localparam logic [3:0] NIB_LEAD2_LO    = 4'hC;
    localparam logic [3:0] NIB_LEAD2_HI    = 4'hD;
    localparam logic [3:0] NIB_LEAD3       = 4'hE;
    localparam logic [3:0] NIB_LEAD4       = 4'hF;
    localparam logic [2:0] LEAD4_LOW_MAX   = 3'b100;

endpackage

// ===== rtl/jsu8_decode.sv =====
// Per-byte decode: next scan state, next position and the result of one byte.
`timescale 1ns / 1ps

module jsu8_decode #(
    parameter int INDEX_BITS = 32
) (
    input  jsu8_pkg::t_scan_state  i_st,
    input  logic [INDEX_BITS-1:0]  i_pos,
    input  logic [INDEX_BITS-1:0]  i_seq_start,
    input  jsu8_pkg::t_in_item     i_item,
    output jsu8_pkg::t_scan_state  o_st,
    output logic [INDEX_BITS-1:0]  o_pos,
    output logic [INDEX_BITS-1:0]  o_seq_start,
    output logic                   o_res_valid,
    output jsu8_pkg::t_out_item    o_res
);

    logic [INDEX_BITS+31:0] start_wide;
    logic [INDEX_BITS-1:0]  start_idx;
    logic [INDEX_BITS-1:0]  cur_pos;
    logic [INDEX_BITS-1:0]  inc_pos;
    logic [INDEX_BITS-1:0]  fin_idx;
    logic [INDEX_BITS+31:0] fin_wide;

    // Fit the 32-bit start index to the index width
    assign start_wide = {{INDEX_BITS{1'b0}}, i_item.start_index};
    assign start_idx  = start_wide[INDEX_BITS-1:0];
    assign cur_pos    = i_st.at_scan_start ? start_idx : i_pos;

    // Saturating increment of the current position
    assign inc_pos = (&cur_pos) ? cur_pos : cur_pos + INDEX_BITS'(1);

    always_comb begin
        logic [7:0]      c;
        logic [3:0]      hi;
        logic [1:0]      rem;
        logic [1:0]      len;
        logic            bad;
        logic            fin;
        jsu8_pkg::t_status fst;
        c    = i_item.data_byte;
        hi   = c[7:4];
        rem  = i_st.at_scan_start ? 2'd0 : i_st.remaining_continuations;
        len  = 2'd3;
        bad  = i_st.sequence_bad;
        fin  = 1'b0;
        fst  = jsu8_pkg::ST_END;
        fin_idx     = '0;
        o_st        = i_st;
        o_pos       = i_pos;
        o_seq_start = i_seq_start;
        if (i_st.discarding) begin
            // Drop bytes until the range ends
            if (i_item.last_byte) begin
                o_st.discarding    = 1'b0;
                o_st.at_scan_start = 1'b1;
            end
        end else begin
            o_pos              = inc_pos;
            o_st.at_scan_start = 1'b0;
            if (i_st.at_scan_start) begin
                o_st.held_lead    = '0;
                o_st.sequence_bad = 1'b0;
                o_seq_start       = '0;
            end
            if (rem == 2'd0) begin
                // Single byte or lead byte
                if (c <= jsu8_pkg::ASCII_MAX) begin
                    if (c == jsu8_pkg::ASCII_QUOTE || c == jsu8_pkg::ASCII_BACKSLASH) begin
                        fin     = 1'b1;
                        fst     = jsu8_pkg::ST_QUOTE;
                        fin_idx = cur_pos;
                    end
                    o_st.remaining_continuations = 2'd0;
                end else if (hi == jsu8_pkg::NIB_LEAD2_LO || hi == jsu8_pkg::NIB_LEAD2_HI) begin
                    o_st.held_lead               = c;
                    o_st.remaining_continuations = 2'd1;
                    o_seq_start                  = cur_pos;
                    o_st.sequence_bad = ((c & jsu8_pkg::LEAD2_PAYLOAD) == 8'h00);
                end else if (hi == jsu8_pkg::NIB_LEAD3) begin
                    o_st.held_lead               = c;
                    o_st.remaining_continuations = 2'd2;
                    o_seq_start                  = cur_pos;
                    o_st.sequence_bad            = 1'b0;
                end else if (hi == jsu8_pkg::NIB_LEAD4) begin
                    o_st.held_lead               = c;
                    o_st.remaining_continuations = 2'd3;
                    o_seq_start                  = cur_pos;
                    o_st.sequence_bad            = (c > jsu8_pkg::LEAD4_MAX);
                end else begin
                    // Stray continuation byte
                    o_st.remaining_continuations = 2'd0;
                    fin = 1'b1;
                    fst = jsu8_pkg::ST_INVALID;
                end
            end else begin
                // Continuation byte of an open sequence
                if (i_st.held_lead[7:4] == jsu8_pkg::NIB_LEAD2_LO ||
                    i_st.held_lead[7:4] == jsu8_pkg::NIB_LEAD2_HI) begin
                    len = 2'd1;
                end else if (i_st.held_lead[7:4] == jsu8_pkg::NIB_LEAD3) begin
                    len = 2'd2;
                end
                if ((c & jsu8_pkg::CONT_MASK) != jsu8_pkg::CONT_TAG) begin
                    bad = 1'b1;
                end
                // First continuation bounds overlong, surrogate and range
                if (rem == len && len >= 2'd2) begin
                    if (len == 2'd2) begin
                        if (i_st.held_lead[3:0] == 4'h0 && (c & jsu8_pkg::CONT_BIT5) == 8'h00)
                            bad = 1'b1;
                        if (i_st.held_lead[3:0] == jsu8_pkg::LEAD3_SURR &&
                            (c & jsu8_pkg::CONT_BIT5) != 8'h00)
                            bad = 1'b1;
                    end else begin
                        if (i_st.held_lead[2:0] == 3'b000 && (c & jsu8_pkg::CONT_BITS54) == 8'h00)
                            bad = 1'b1;
                        if (i_st.held_lead[2:0] == jsu8_pkg::LEAD4_LOW_MAX &&
                            (c & jsu8_pkg::CONT_BITS54) != 8'h00)
                            bad = 1'b1;
                    end
                end
                o_st.sequence_bad            = bad;
                o_st.remaining_continuations = rem - 2'd1;
                if (rem == 2'd1) begin
                    if (bad) begin
                        fin = 1'b1;
                        fst = jsu8_pkg::ST_INVALID;
                    end else begin
                        o_st.held_lead    = '0;
                        o_st.sequence_bad = 1'b0;
                        o_seq_start       = '0;
                    end
                end
            end
            // End of range
            if (!fin && i_item.last_byte) begin
                fin = 1'b1;
                if (o_st.remaining_continuations != 2'd0) begin
                    fst     = jsu8_pkg::ST_INCOMPLETE;
                    fin_idx = o_seq_start;
                end else begin
                    fst     = jsu8_pkg::ST_END;
                    fin_idx = inc_pos;
                end
            end
            // Close the scan
            if (fin) begin
                o_st.remaining_continuations = 2'd0;
                o_st.held_lead               = '0;
                o_st.sequence_bad            = 1'b0;
                o_seq_start                  = '0;
                o_st.at_scan_start           = 1'b1;
                o_st.discarding              = !i_item.last_byte;
            end
        end
        o_res_valid   = fin;
        o_res.status  = fst;
        // Low 32 bits of the result index
        fin_wide         = {32'h0, fin_idx};
        o_res.stop_index = fin_wide[31:0];
    end

endmodule

// ===== rtl/json_string_utf8_scanner_core.sv =====
// The ending byte is held in the input register, then its result in the result register.
// Throughput: one byte per cycle unless a result waits untaken; the input register, decode
// logic and result register run in a single pass with no iteration.
// Reset: synchronous active-low reset empties both registers and starts a fresh scan
// with no open sequence.
// Top level: input register, per-byte decode and result register of the scanner.
`timescale 1ns / 1ps

module json_string_utf8_scanner_core #(
    parameter int INDEX_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  jsu8_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output jsu8_pkg::t_out_item o_out_data
);

    logic                  r_in_valid;
    jsu8_pkg::t_in_item    r_in;
    jsu8_pkg::t_scan_state r_st;
    jsu8_pkg::t_scan_state n_st;
    logic [INDEX_BITS-1:0] r_pos;
    logic [INDEX_BITS-1:0] n_pos;
    logic [INDEX_BITS-1:0] r_seq_start;
    logic [INDEX_BITS-1:0] n_seq_start;
    logic                  r_out_valid;
    jsu8_pkg::t_out_item   r_out;
    logic                  res_valid;
    jsu8_pkg::t_out_item   res;
    logic                  advance;

    // Advance the held byte unless its result would overwrite a waiting one
    assign advance    = r_in_valid && (!res_valid || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    jsu8_decode #(
        .INDEX_BITS (INDEX_BITS)
    ) u_decode (
        .i_st        (r_st),
        .i_pos       (r_pos),
        .i_seq_start (r_seq_start),
        .i_item      (r_in),
        .o_st        (n_st),
        .o_pos       (n_pos),
        .o_seq_start (n_seq_start),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.remaining_continuations <= 2'd0;
            r_st.held_lead               <= '0;
            r_st.sequence_bad            <= 1'b0;
            r_st.discarding              <= 1'b0;
            r_st.at_scan_start           <= 1'b1;
            r_pos                        <= '0;
            r_seq_start                  <= '0;
        end else if (advance) begin
            r_st        <= n_st;
            r_pos       <= n_pos;
            r_seq_start <= n_seq_start;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A new result never lands on one still waiting
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && res_valid) |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");

    // A byte flagged last always leaves the block ready for a new scan
    a_last_restarts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in.last_byte) |=> r_st.at_scan_start)
        else $error("scan not closed after last byte");

    // No sequence is open while dropping bytes
    a_drop_no_seq : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.discarding |-> (r_st.remaining_continuations == 2'd0))
        else $error("open sequence while discarding");

    // An open sequence implies a scan in progress
    a_seq_in_scan : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.remaining_continuations != 2'd0) |-> !r_st.at_scan_start)
        else $error("open sequence at scan start");

endmodule
